[hdl/quaternion_to_euler_unit_defines.svh]
// Assertion macros for the quaternion to Euler unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef QUATERNION_TO_EULER_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define Q2E_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e check failed");

// Next-cycle implication.
`define Q2E_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e check failed");

`endif

[hdl/q2e_pkg.sv]
// Types and constants shared by the quaternion to Euler cells and top level.
// No dependencies.
package q2e_pkg;

	localparam int SQRT_STEPS = 31;
	localparam int TAB_LEN    = 24;

	localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
	localparam logic signed [33:0] HALF_Q30  = 34'sd536870912;
	localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
	localparam logic signed [19:0] ANGLE_MAX = 20'sd25736;
	localparam logic signed [19:0] PITCH_MAX = 20'sd12868;

	localparam logic signed [35:0] ATAN_TAB [TAB_LEN] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
		36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
		36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
		36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
		36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
		36'sd1024,      36'sd512,       36'sd256,       36'sd128
	};

	// operands riding along the square root chain
	typedef struct packed {
		logic signed [33:0] roll_num;
		logic signed [33:0] roll_den;
		logic signed [33:0] yaw_num;
		logic signed [33:0] yaw_den;
		logic signed [31:0] s;
	} q2e_carry_t;

	typedef struct packed {
		logic [60:0] rem;
		logic [61:0] root;
	} q2e_sqrt_t;

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [35:0] acc;
		logic               zero;
	} q2e_lane_t;

	typedef struct packed {
		q2e_lane_t roll;
		q2e_lane_t pitch;
		q2e_lane_t yaw;
	} q2e_trio_t;

endpackage

[hdl/quaternion_to_euler_unit.sv]
// Quaternion (Q1.15) to ZYX Euler angles (Q3.13 radians), top level.
// Depends on q2e_pkg, q2e_sqrt_cell, q2e_cordic_cell and the defines header.
//
// One quaternion is taken every clock unless in_stall is high, and each gives
// one roll/pitch/yaw item after one product stage, one sum stage, one
// squaring stage, 31 square root cells for the arcsine cosine side, then
// CORDIC_STEPS rotation cells shared by all three angles and one rounding
// stage. The whole pipeline holds while a finished item waits under
// out_stall; out_valid never depends on out_stall.
`include "quaternion_to_euler_unit_defines.svh"

module quaternion_to_euler_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);

	localparam int NS = q2e_pkg::SQRT_STEPS;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: products
	logic               valid_s1;
	logic signed [31:0] ww_s1, xx_s1, zz_s1, wx_s1, yz_s1, wz_s1, xy_s1, wy_s1, xz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			zz_s1 <= quat_z * quat_z;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
		end
	end

	// stage 2: sums and the saturated arcsine argument
	logic                valid_s2;
	q2e_pkg::q2e_carry_t cy_s2;
	logic [30:0]         mag_s2;
	logic signed [33:0]  s_raw;
	logic signed [31:0]  s_sat;

	always_comb begin
		s_raw = ({{2{wy_s1[31]}}, wy_s1} - {{2{xz_s1[31]}}, xz_s1}) <<< 1;
		if (s_raw > q2e_pkg::ONE_Q30) begin
			s_sat = q2e_pkg::ONE_Q30[31:0];
		end else if (s_raw < -q2e_pkg::ONE_Q30) begin
			s_sat = -q2e_pkg::ONE_Q30[31:0];
		end else begin
			s_sat = s_raw[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cy_s2.roll_num <= {{2{wx_s1[31]}}, wx_s1} + {{2{yz_s1[31]}}, yz_s1};
			cy_s2.roll_den <= {{2{ww_s1[31]}}, ww_s1} + {{2{zz_s1[31]}}, zz_s1}
				- q2e_pkg::HALF_Q30;
			cy_s2.yaw_num  <= {{2{wz_s1[31]}}, wz_s1} + {{2{xy_s1[31]}}, xy_s1};
			cy_s2.yaw_den  <= {{2{ww_s1[31]}}, ww_s1} + {{2{xx_s1[31]}}, xx_s1}
				- q2e_pkg::HALF_Q30;
			cy_s2.s        <= s_sat;
			mag_s2         <= s_sat[31] ? 31'(-s_sat) : s_sat[30:0];
		end
	end

	// stage 3: square of the argument
	logic                valid_s3;
	q2e_pkg::q2e_carry_t cy_s3;
	logic [61:0]         sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cy_s3 <= cy_s2;
			sq_s3 <= mag_s2 * mag_s2;
		end
	end

	// square root chain
	logic                sv  [NS+1];
	q2e_pkg::q2e_sqrt_t  sst [NS+1];
	q2e_pkg::q2e_carry_t scy [NS+1];

	assign sv[0]       = valid_s3;
	assign sst[0].rem  = 61'(62'd1 << 60) - sq_s3[60:0];
	assign sst[0].root = '0;
	assign scy[0]      = cy_s3;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		q2e_sqrt_cell #(.BITPOS(60 - 2 * k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (sv[k]),
			.st_in    (sst[k]),
			.cy_in    (scy[k]),
			.valid_q  (sv[k+1]),
			.st_q     (sst[k+1]),
			.cy_q     (scy[k+1])
		);
	end

	// fold a negative denominator through 180 degrees
	function automatic q2e_pkg::q2e_lane_t prep(logic signed [35:0] num,
		logic signed [35:0] den);
		q2e_pkg::q2e_lane_t l;
		l.zero = (num == '0) && (den == '0);
		if (den[35]) begin
			l.acc = num[35] ? -q2e_pkg::PI_Q30 : q2e_pkg::PI_Q30;
			l.x   = -den;
			l.y   = -num;
		end else begin
			l.acc = '0;
			l.x   = den;
			l.y   = num;
		end
		return l;
	endfunction

	logic               cv  [CORDIC_STEPS+1];
	q2e_pkg::q2e_trio_t ctr [CORDIC_STEPS+1];
	q2e_pkg::q2e_carry_t cy_end;

	assign cy_end        = scy[NS];
	assign cv[0]         = sv[NS];
	assign ctr[0].roll   = prep(36'(cy_end.roll_num), 36'(cy_end.roll_den));
	assign ctr[0].pitch  = prep(36'(cy_end.s), {5'd0, sst[NS].root[30:0]});
	assign ctr[0].yaw    = prep(36'(cy_end.yaw_num), 36'(cy_end.yaw_den));

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		q2e_cordic_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (cv[k]),
			.tr_in    (ctr[k]),
			.valid_q  (cv[k+1]),
			.tr_q     (ctr[k+1])
		);
	end

	// round half up to Q3.13 and clamp
	function automatic logic signed [15:0] finish(q2e_pkg::q2e_lane_t l,
		logic signed [19:0] lim);
		logic signed [36:0] t;
		logic signed [19:0] r;
		t = {l.acc[35], l.acc} + 37'sd65536;
		r = t[36:17];
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		if (l.zero) begin
			r = '0;
		end
		return r[15:0];
	endfunction

	logic               out_valid_q;
	logic signed [15:0] roll_q, yaw_q, pitch_full;
	logic signed [14:0] pitch_q;

	assign pitch_full = finish(ctr[CORDIC_STEPS].pitch, q2e_pkg::PITCH_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= finish(ctr[CORDIC_STEPS].roll, q2e_pkg::ANGLE_MAX);
			pitch_q <= pitch_full[14:0];
			yaw_q   <= finish(ctr[CORDIC_STEPS].yaw, q2e_pkg::ANGLE_MAX);
		end
	end

	assign out_valid   = out_valid_q;
	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

	`Q2E_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, valid_s1)
	`Q2E_ASSERT_IMP(a_backpressure, out_valid && out_stall, in_stall)
	`Q2E_ASSERT_NXT(a_stage_holds, valid_s1 && !adv, valid_s1)

endmodule

[hdl/q2e_sqrt_cell.sv]
// One bit of the integer square root, registered.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
	parameter int BITPOS = 60
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_in,
	input  q2e_pkg::q2e_sqrt_t  st_in,
	input  q2e_pkg::q2e_carry_t cy_in,
	output logic                valid_q,
	output q2e_pkg::q2e_sqrt_t  st_q,
	output q2e_pkg::q2e_carry_t cy_q
);

	localparam logic [61:0] BIT = 62'd1 << BITPOS;

	logic [61:0]        trial;
	q2e_pkg::q2e_sqrt_t st_nx;

	always_comb begin
		trial = st_in.root + BIT;
		if ({1'b0, st_in.rem} >= trial) begin
			st_nx.rem  = st_in.rem - trial[60:0];
			st_nx.root = (st_in.root >> 1) + BIT;
		end else begin
			st_nx.rem  = st_in.rem;
			st_nx.root = st_in.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= st_nx;
			cy_q <= cy_in;
		end
	end

endmodule

[hdl/q2e_cordic_cell.sv]
// One vectoring CORDIC rotation for the roll, pitch and yaw lanes.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_in,
	input  q2e_pkg::q2e_trio_t tr_in,
	output logic               valid_q,
	output q2e_pkg::q2e_trio_t tr_q
);

	localparam logic signed [35:0] ANG = q2e_pkg::ATAN_TAB[IDX];

	function automatic q2e_pkg::q2e_lane_t rot(q2e_pkg::q2e_lane_t l);
		q2e_pkg::q2e_lane_t r;
		logic signed [35:0] dx;
		logic signed [35:0] dy;
		dx = l.y >>> IDX;
		dy = l.x >>> IDX;
		r  = l;
		if (!l.y[35]) begin
			r.x   = l.x + dx;
			r.y   = l.y - dy;
			r.acc = l.acc + ANG;
		end else begin
			r.x   = l.x - dx;
			r.y   = l.y + dy;
			r.acc = l.acc - ANG;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tr_q.roll  <= rot(tr_in.roll);
			tr_q.pitch <= rot(tr_in.pitch);
			tr_q.yaw   <= rot(tr_in.yaw);
		end
	end

endmodule
